>>> rtl/core/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

  // bits of the dividend consumed per divide cycle
  localparam int unsigned STEP_BITS = 8;

  localparam int unsigned RADIX_W = 4;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic load;       // latch value, radix; clear digit stack
    logic div_step;   // one chunk of long division
    logic pop;        // read top digit of the stack
    logic emit_sign;  // character port shows '-'
  } itoa_cmd_t;

  typedef struct packed {
    logic neg;        // latched value was negative
    logic pass_last;  // current divide cycle finishes a digit
    logic w_zero;     // remaining quotient is zero
    logic cnt_zero;   // digit stack empty
  } itoa_sts_t;

endpackage

>>> rtl/core/integer_to_radix_ascii_unit.sv
`timescale 1ns / 1ps

// channel  | ports                          | handshake
// ---------+--------------------------------+-------------------------------
// input    | in_value                       | taken when start && !busy
// result   | out_character, out_last        | one beat per out_valid cycle
// config   | cfg_wdata (radix)              | written when cfg_we
//
// Each digit is found by dividing the value by the radix in 8-bit chunks (S_DIV)
// and checked (S_CHECK); then the sign, if negative, goes out from S_SIGN, and each
// character is read from the digit stack (S_POP) and shown (S_EMIT).
// A new value is taken only once all characters of the last one are out.
// Synchronous active-low reset; radix resets to 10. Results cannot be stalled.
module integer_to_radix_ascii_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [VALUE_BITS-1:0]        in_value,
  output logic                         out_valid,
  output logic [7:0]                   out_character,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [itoa_pkg::RADIX_W-1:0] cfg_wdata
);

  itoa_pkg::itoa_cmd_t cmd;
  itoa_pkg::itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .out_last  (out_last),
    .sts       (sts),
    .cmd       (cmd)
  );

  itoa_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_character (out_character)
  );

endmodule

>>> rtl/core/itoa_dp.sv
`timescale 1ns / 1ps

module itoa_dp #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [itoa_pkg::RADIX_W-1:0]         cfg_wdata,
  input  logic [VALUE_BITS-1:0]                in_value,
  input  itoa_pkg::itoa_cmd_t                  cmd,
  output itoa_pkg::itoa_sts_t                  sts,
  output logic [7:0]                           out_character
);

  localparam int unsigned SB      = itoa_pkg::STEP_BITS;
  localparam int unsigned PASSES  = (VALUE_BITS + SB - 1) / SB;
  localparam int unsigned MAG_W   = PASSES * SB;
  localparam int unsigned PASS_W  = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int unsigned DIG_AW  = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int unsigned RW      = itoa_pkg::RADIX_W;

  logic [RW-1:0]     radix_r;
  logic [RW-1:0]     rdx_r;
  logic              neg_r;
  logic [MAG_W-1:0]  w_r;
  logic [MAG_W-1:0]  q_r;
  logic [RW-1:0]     rem_r;
  logic [PASS_W-1:0] pass_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RW-1:0]     rd_data_r;

  logic [RW-1:0]     digit_mem [VALUE_BITS];

  logic [RW-1:0]         rdx_nxt;
  logic [VALUE_BITS-1:0] mag;
  logic [SB-1:0]         chunk;
  logic [SB-1:0]         qbits;
  logic [RW:0]           rem5;
  logic [RW-1:0]         rem_nxt;
  logic [MAG_W-1:0]      quot_nxt;
  logic [CNT_W-1:0]      cnt_dec;
  logic                  pass_last;

  // saturate the radix register to two..ten
  always_comb begin
    priority if (radix_r < itoa_pkg::RADIX_MIN) begin
      rdx_nxt = itoa_pkg::RADIX_MIN;
    end else if (radix_r > itoa_pkg::RADIX_MAX) begin
      rdx_nxt = itoa_pkg::RADIX_MAX;
    end else begin
      rdx_nxt = radix_r;
    end
  end

  // unsigned magnitude; the most negative value maps to itself as unsigned
  assign mag = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;

  // restoring division of one chunk by the radix, remainder stays below radix
  always_comb begin
    chunk = w_r[MAG_W-1 -: SB];
    rem5  = {1'b0, rem_r};
    qbits = '0;
    for (int i = SB - 1; i >= 0; i--) begin
      rem5 = {rem5[RW-1:0], chunk[i]};
      if (rem5 >= {1'b0, rdx_r}) begin
        rem5     = rem5 - {1'b0, rdx_r};
        qbits[i] = 1'b1;
      end
    end
    rem_nxt = rem5[RW-1:0];
  end

  assign quot_nxt  = (q_r << SB) | MAG_W'(qbits);
  assign pass_last = (pass_r == PASS_W'(PASSES - 1));
  assign cnt_dec   = cnt_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= itoa_pkg::RADIX_RESET;
      cnt_r   <= '0;
      pass_r  <= '0;
      rem_r   <= '0;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (cmd.load) begin
        cnt_r  <= '0;
        pass_r <= '0;
        rem_r  <= '0;
      end else if (cmd.div_step) begin
        if (pass_last) begin
          pass_r <= '0;
          rem_r  <= '0;
          cnt_r  <= cnt_r + CNT_W'(1);
        end else begin
          pass_r <= pass_r + PASS_W'(1);
          rem_r  <= rem_nxt;
        end
      end else if (cmd.pop) begin
        cnt_r <= cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdx_r <= rdx_nxt;
      neg_r <= in_value[VALUE_BITS-1];
      w_r   <= MAG_W'(mag);
    end else if (cmd.div_step) begin
      if (pass_last) begin
        w_r <= quot_nxt;
      end else begin
        w_r <= w_r << SB;
        q_r <= quot_nxt;
      end
    end
  end

  // digit stack: least significant digit pushed first, popped last
  always_ff @(posedge clk) begin
    if (cmd.div_step && pass_last) begin
      digit_mem[cnt_r[DIG_AW-1:0]] <= rem_nxt;
    end
    if (cmd.pop) begin
      rd_data_r <= digit_mem[cnt_dec[DIG_AW-1:0]];
    end
  end

  assign sts.neg       = neg_r;
  assign sts.pass_last = pass_last;
  assign sts.w_zero    = (w_r == '0);
  assign sts.cnt_zero  = (cnt_r == '0);

  assign out_character = cmd.emit_sign ? itoa_pkg::CHAR_MINUS
                                       : (itoa_pkg::CHAR_ZERO + {4'b0, rd_data_r});

endmodule

>>> rtl/core/itoa_ctrl.sv
`timescale 1ns / 1ps

module itoa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output logic                out_last,
  input  itoa_pkg::itoa_sts_t sts,
  output itoa_pkg::itoa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SIGN,
    S_POP,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_DIV;
      S_DIV:   if (sts.pass_last) state_nxt = S_CHECK;
      S_CHECK: begin
        if (!sts.w_zero) begin
          state_nxt = S_DIV;
        end else if (sts.neg) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_SIGN:  state_nxt = S_POP;
      S_POP:   state_nxt = S_EMIT;
      S_EMIT:  state_nxt = sts.cnt_zero ? S_IDLE : S_POP;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.load      = (state_r == S_IDLE) && start;
  assign cmd.div_step  = (state_r == S_DIV);
  assign cmd.pop       = (state_r == S_POP);
  assign cmd.emit_sign = (state_r == S_SIGN);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SIGN) || (state_r == S_EMIT);
  assign out_last  = (state_r == S_EMIT) && sts.cnt_zero;

  a_beat_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat while idle");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == S_DIV)) else $error("start not taken");

  a_sign_then_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_sign |=> cmd.pop) else $error("sign not followed by digit read");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !busy) else $error("busy after last beat");

endmodule

>>> test/tb_integer_to_radix_ascii_unit.sv
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii_unit;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  // Predicts the character stream for each accepted value and checks the
  // out_ beats against it in order.
  class itoa_text_board;
    char_beat_t                   want_q[$];
    logic [itoa_pkg::RADIX_W-1:0] radix;
    int unsigned                  errors;

    function new();
      radix = itoa_pkg::RADIX_RESET;
      errors = 0;
    endfunction

    function void set_radix(logic [itoa_pkg::RADIX_W-1:0] r);
      radix = r;
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    function void note_value(logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0]           mag;
      logic [itoa_pkg::RADIX_W-1:0] base;
      logic                         neg;
      logic [7:0]                   digit_q[$];
      char_beat_t                   beat;
      neg = value[VALUE_W-1];
      // most negative value wraps onto its own magnitude, which is what we want
      mag = neg ? ({VALUE_W{1'b0}} - value) : value;
      if (radix < itoa_pkg::RADIX_MIN) begin
        base = itoa_pkg::RADIX_MIN;
      end else if (radix > itoa_pkg::RADIX_MAX) begin
        base = itoa_pkg::RADIX_MAX;
      end else begin
        base = radix;
      end
      do begin
        digit_q.push_front(itoa_pkg::CHAR_ZERO + 8'(mag % base));
        mag = mag / base;
      end while (mag != 0);
      if (neg) begin
        beat.ch = itoa_pkg::CHAR_MINUS;
        beat.last = 1'b0;
        want_q.push_back(beat);
      end
      for (int k = 0; k < digit_q.size(); k++) begin
        beat.ch = digit_q[k];
        beat.last = (k == digit_q.size() - 1);
        want_q.push_back(beat);
      end
    endfunction

    function void flag(string what, char_beat_t want, logic [7:0] ch, logic last);
      errors++;
      if (errors <= 10) begin
        $display("%0t: %s: expected char %h last %b, got char %h last %b",
                 $time, what, want.ch, want.last, ch, last);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      char_beat_t want;
      if (want_q.size() == 0) begin
        want.ch = 8'hxx;
        want.last = 1'bx;
        flag("unexpected beat", want, ch, last);
      end else begin
        want = want_q.pop_front();
        if (ch !== want.ch || last !== want.last) begin
          flag("mismatch", want, ch, last);
        end
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [VALUE_W-1:0]           in_value;
  logic                         out_valid;
  logic [7:0]                   out_character;
  logic                         out_last;
  logic                         cfg_we;
  logic [itoa_pkg::RADIX_W-1:0] cfg_wdata;

  itoa_text_board board;
  int unsigned    cycles;

  integer_to_radix_ascii_unit #(
    .VALUE_BITS(VALUE_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_char(out_character, out_last);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_value(logic [VALUE_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_value(v);
  endtask

  task automatic hold_off(int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    in_value <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // drop start and wait until every character has come out and the unit is idle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_radix(logic [itoa_pkg::RADIX_W-1:0] r);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    board.set_radix(r);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: v = {VALUE_W{1'b0}} - $urandom_range(1, 40);
      3: v = 32'h7fff_ffff - $urandom_range(0, 3);
      4: v = 32'h8000_0000 + $urandom_range(0, 3);
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = {VALUE_W{1'b0}} - v;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [itoa_pkg::RADIX_W-1:0] radix_plan[16];
    int unsigned                  burst_left;
    radix_plan = '{4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd11,
                   4'd12, 4'd13, 4'd14, 4'd15, 4'd2, 4'd10, 4'd0, 4'd1};
    board = new();
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset radix (ten): zero, sign handling, digit rollover, both extremes
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hffff_fff6);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    drain();

    // binary gives the longest strings
    write_radix(itoa_pkg::RADIX_MIN);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd2);
    drain();

    // out-of-range radix saturates low and high
    write_radix(4'd0);
    send_value(32'h8000_0000);
    send_value(32'd5);
    drain();
    write_radix(4'd15);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    drain();

    burst_left = 0;
    foreach (radix_plan[p]) begin
      write_radix(radix_plan[p]);
      for (int n = 0; n < 6; n++) begin
        send_value(pick_value());
        if (burst_left == 0) begin
          hold_off($urandom_range(1, 10));
          burst_left = $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
